@@ rtl/irrb_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and state codes of the IRR bisection solver.
package irrb_pkg;

  localparam int MaxMonths    = 1024;
  localparam int RateFracBits = 32;

  localparam int CountW = $clog2(MaxMonths + 1);
  localparam int AddrW  = (MaxMonths > 1) ? $clog2(MaxMonths) : 1;
  localparam int MoneyW = 40;
  localparam int RateW  = 41;
  localparam int StepsW = 7;
  localparam int SumW   = 64;
  localparam int MagW   = SumW - 1;
  localparam int GrowW  = RateW;
  localparam int ProdW  = MagW + GrowW;
  localparam int MulW   = 32;

  localparam logic [StepsW-1:0] StepsReset = StepsW'(100);

  localparam longint OneRaw = (RateFracBits > 39) ? (64'sd1 <<< 39)
                                                  : (64'sd1 <<< RateFracBits);
  localparam logic signed [RateW-1:0] RateOne = RateW'(OneRaw);
  localparam logic signed [RateW-1:0] RateCap = RateW'(64'sd1 <<< 39);
  localparam longint LowRaw = -(((longint'(999) <<< RateFracBits) + 500) / 1000);
  localparam logic signed [RateW-1:0] RateLow = RateW'(LowRaw);

  localparam logic signed [SumW-1:0] SatMax = {1'b0, {(SumW-1){1'b1}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FV_INIT,
    ST_RD,
    ST_ADD,
    ST_MUL,
    ST_MACC,
    ST_RND,
    ST_CMP,
    ST_MID,
    ST_DONE
  } irrb_state_t;

  typedef struct packed {
    logic       clear;
    logic       mul_en;
    logic [1:0] sel;
  } irrb_mac_ctrl_t;

endpackage

@@ rtl/irrb_req_if.sv @@
`timescale 1ns / 1ps
// Request channel: monthly amounts and solve items.
interface irrb_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 req_type;
  logic signed [irrb_pkg::MoneyW-1:0]   money_value;

  modport source (output valid, output req_type, output money_value, input ready);
  modport sink   (input valid, input req_type, input money_value, output ready);
endinterface

@@ rtl/irrb_rsp_if.sv @@
`timescale 1ns / 1ps
// Response channel: solved monthly rate and overflow flag.
interface irrb_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [irrb_pkg::RateW-1:0]   monthly_rate;
  logic                                store_overflow;

  modport source (output valid, output monthly_rate, output store_overflow, input ready);
  modport sink   (input valid, input monthly_rate, input store_overflow, output ready);
endinterface

@@ rtl/irrb_store.sv @@
`timescale 1ns / 1ps
// Amount memory: one write port, one registered read port.
module irrb_store (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [irrb_pkg::AddrW-1:0]          wr_addr,
  input  logic signed [irrb_pkg::MoneyW-1:0]  wr_data,
  input  logic [irrb_pkg::AddrW-1:0]          rd_addr,
  output logic signed [irrb_pkg::MoneyW-1:0]  rd_data
);

  logic signed [irrb_pkg::MoneyW-1:0] mem [irrb_pkg::MaxMonths];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/irrb_mac.sv @@
`timescale 1ns / 1ps
// Shared 32x32 multiplier with partial-product accumulator.
module irrb_mac (
  input  logic                          clk,
  input  logic                          rst,
  input  irrb_pkg::irrb_mac_ctrl_t      ctrl,
  input  logic [irrb_pkg::MagW-1:0]     mag,
  input  logic [irrb_pkg::GrowW-1:0]    grow,
  output logic [irrb_pkg::ProdW-1:0]    prod
);

  logic [irrb_pkg::MulW-1:0]   a_half;
  logic [irrb_pkg::MulW-1:0]   b_half;
  logic [2*irrb_pkg::MulW-1:0] pp;
  logic [1:0]                  pp_sel;
  logic                        pp_vld;
  logic [irrb_pkg::ProdW-1:0]  pp_placed;

  assign a_half = ctrl.sel[1] ? irrb_pkg::MulW'(mag >> irrb_pkg::MulW)
                              : mag[irrb_pkg::MulW-1:0];
  assign b_half = ctrl.sel[0] ? irrb_pkg::MulW'(grow >> irrb_pkg::MulW)
                              : grow[irrb_pkg::MulW-1:0];

  always_comb begin
    unique case (pp_sel)
      2'd0:    pp_placed = irrb_pkg::ProdW'(pp);
      2'd1,
      2'd2:    pp_placed = irrb_pkg::ProdW'(pp) << irrb_pkg::MulW;
      default: pp_placed = irrb_pkg::ProdW'(pp) << (2 * irrb_pkg::MulW);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pp_vld <= 1'b0;
    end else begin
      pp_vld <= ctrl.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      pp     <= a_half * b_half;
      pp_sel <= ctrl.sel;
    end
    if (ctrl.clear) begin
      prod <= '0;
    end else if (pp_vld) begin
      prod <= prod + pp_placed;
    end
  end

endmodule

@@ rtl/irr_bisection_solver.sv @@
`timescale 1ns / 1ps
// Internal rate of return solver: bisection over a Horner future value.
//
// Usage:
//   req channel: req_type 0 appends money_value to the amount store (one item a
//   cycle while idle, no response); req_type 1 gives the target final value and
//   starts a solve. rsp channel: one item per solve with the monthly rate (Q8.32)
//   and the overflow flag. cfg_wr_en/cfg_wr_data set bisection_steps (reset 100,
//   0 acts as 1); write it only while no solve is running.
// Evaluation and solve sequence:
//   One future-value evaluation over N stored months runs, per month, one
//   memory read, one saturating add, four passes through the shared 32x32
//   multiplier, one accumulate and one round. Each bisection step adds one
//   midpoint state. A solve runs E expansion evaluations (1 to 8) and S bisection
//   evaluations, then loads the result; req is not ready meanwhile.
// Reset: clears count, overflow flag, bounds and output valid; the store is not
//   cleared, so no clearing pass is needed.
// Stall: the result waits in the output register; the block goes back to
//   accepting appends once it is loaded, even while rsp is held.
module irr_bisection_solver (
  input  logic                               clk,
  input  logic                               rst,
  irrb_req_if.sink                           req,
  irrb_rsp_if.source                         rsp,
  input  logic                               cfg_wr_en,
  input  logic [irrb_pkg::StepsW-1:0]        cfg_wr_data
);

  irrb_pkg::irrb_state_t state, state_next;

  logic [irrb_pkg::StepsW-1:0]        bisection_steps;
  logic [irrb_pkg::StepsW-1:0]        steps_last;
  logic [irrb_pkg::CountW-1:0]        month_count;
  logic                               overflow_seen;
  logic signed [irrb_pkg::RateW-1:0]  low_bound;
  logic signed [irrb_pkg::RateW-1:0]  high_bound;
  logic signed [irrb_pkg::RateW-1:0]  rate;
  logic signed [irrb_pkg::SumW-1:0]   horner_sum;
  logic [irrb_pkg::StepsW-1:0]        step_count;
  logic signed [irrb_pkg::MoneyW-1:0] target;
  logic                               expanding;
  logic [irrb_pkg::CountW-1:0]        t_idx;
  logic [1:0]                         mul_idx;
  logic                               acc_neg;
  logic [irrb_pkg::MagW-1:0]          acc_mag;

  logic                               rsp_valid;
  logic signed [irrb_pkg::RateW-1:0]  out_rate;
  logic                               out_ovf;
  logic                               out_free;

  logic                               store_we;
  logic signed [irrb_pkg::MoneyW-1:0] rd_data;
  irrb_pkg::irrb_mac_ctrl_t           mac_ctrl;
  logic [irrb_pkg::ProdW-1:0]         prod;

  logic signed [irrb_pkg::RateW:0]    growth;
  logic                               growth_pos;
  logic signed [irrb_pkg::SumW:0]     add_wide;
  logic signed [irrb_pkg::SumW-1:0]   add_sat;
  logic [irrb_pkg::ProdW-1:0]         prod_rnd;
  logic [irrb_pkg::ProdW-1:0]         prod_q;
  logic signed [irrb_pkg::SumW-1:0]   grow_mag;
  logic signed [irrb_pkg::SumW-1:0]   grow_res;
  logic signed [irrb_pkg::RateW:0]    bound_sum;
  logic                               last_month;
  logic                               keep_expanding;

  irrb_store u_store (
    .clk     (clk),
    .wr_en   (store_we),
    .wr_addr (month_count[irrb_pkg::AddrW-1:0]),
    .wr_data (req.money_value),
    .rd_addr (t_idx[irrb_pkg::AddrW-1:0]),
    .rd_data (rd_data)
  );

  irrb_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .mag  (acc_mag),
    .grow (growth[irrb_pkg::GrowW-1:0]),
    .prod (prod)
  );

  assign steps_last = (bisection_steps == '0) ? '0 : bisection_steps - 1'b1;
  assign out_free   = !rsp_valid || rsp.ready;
  assign req.ready  = (state == irrb_pkg::ST_IDLE);

  assign growth     = {rate[irrb_pkg::RateW-1], rate}
                    + ((irrb_pkg::RateW+1)'(1) << irrb_pkg::RateFracBits);
  assign growth_pos = !growth[irrb_pkg::RateW] && (growth != '0);

  assign add_wide = {horner_sum[irrb_pkg::SumW-1], horner_sum}
                  + (irrb_pkg::SumW+1)'(rd_data);

  always_comb begin
    priority if (add_wide > (irrb_pkg::SumW+1)'(irrb_pkg::SatMax)) begin
      add_sat = irrb_pkg::SatMax;
    end else if (add_wide < -(irrb_pkg::SumW+1)'(irrb_pkg::SatMax)) begin
      add_sat = -irrb_pkg::SatMax;
    end else begin
      add_sat = add_wide[irrb_pkg::SumW-1:0];
    end
  end

  assign prod_rnd = prod + (irrb_pkg::ProdW'(1) << (irrb_pkg::RateFracBits - 1));
  assign prod_q   = prod_rnd >> irrb_pkg::RateFracBits;
  assign grow_mag = (prod_q > irrb_pkg::ProdW'(irrb_pkg::SatMax)) ? irrb_pkg::SatMax
                  : prod_q[irrb_pkg::SumW-1:0];
  assign grow_res = !growth_pos ? '0 : (acc_neg ? -grow_mag : grow_mag);

  assign bound_sum      = {low_bound[irrb_pkg::RateW-1], low_bound}
                        + {high_bound[irrb_pkg::RateW-1], high_bound};
  assign last_month     = (t_idx + 1'b1) == month_count;
  assign keep_expanding = (horner_sum < irrb_pkg::SumW'(target))
                        && (high_bound < irrb_pkg::RateCap);

  always_comb begin
    state_next = state;
    mac_ctrl   = '0;
    store_we   = 1'b0;
    unique case (state)
      irrb_pkg::ST_IDLE: begin
        if (req.valid) begin
          if (req.req_type) begin
            state_next = irrb_pkg::ST_FV_INIT;
          end else begin
            store_we = (month_count < irrb_pkg::CountW'(irrb_pkg::MaxMonths));
          end
        end
      end
      irrb_pkg::ST_FV_INIT: begin
        state_next = (month_count == '0) ? irrb_pkg::ST_CMP : irrb_pkg::ST_RD;
      end
      irrb_pkg::ST_RD: begin
        state_next = irrb_pkg::ST_ADD;
      end
      irrb_pkg::ST_ADD: begin
        mac_ctrl.clear = 1'b1;
        state_next     = irrb_pkg::ST_MUL;
      end
      irrb_pkg::ST_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.sel    = mul_idx;
        if (mul_idx == 2'd3) begin
          state_next = irrb_pkg::ST_MACC;
        end
      end
      irrb_pkg::ST_MACC: begin
        state_next = irrb_pkg::ST_RND;
      end
      irrb_pkg::ST_RND: begin
        state_next = last_month ? irrb_pkg::ST_CMP : irrb_pkg::ST_RD;
      end
      irrb_pkg::ST_CMP: begin
        if (expanding) begin
          state_next = keep_expanding ? irrb_pkg::ST_FV_INIT : irrb_pkg::ST_MID;
        end else begin
          state_next = (step_count == steps_last) ? irrb_pkg::ST_DONE : irrb_pkg::ST_MID;
        end
      end
      irrb_pkg::ST_MID: begin
        state_next = irrb_pkg::ST_FV_INIT;
      end
      irrb_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = irrb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = irrb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= irrb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bisection_steps <= irrb_pkg::StepsReset;
    end else if (cfg_wr_en) begin
      bisection_steps <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      month_count   <= '0;
      overflow_seen <= 1'b0;
      low_bound     <= '0;
      high_bound    <= '0;
      horner_sum    <= '0;
      step_count    <= '0;
      expanding     <= 1'b0;
      t_idx         <= '0;
      mul_idx       <= '0;
      rate          <= '0;
    end else begin
      unique case (state)
        irrb_pkg::ST_IDLE: begin
          if (req.valid) begin
            if (req.req_type) begin
              low_bound  <= irrb_pkg::RateLow;
              high_bound <= irrb_pkg::RateOne;
              rate       <= irrb_pkg::RateOne;
              expanding  <= 1'b1;
              step_count <= '0;
            end else if (store_we) begin
              month_count <= month_count + 1'b1;
            end else begin
              overflow_seen <= 1'b1;
            end
          end
        end
        irrb_pkg::ST_FV_INIT: begin
          horner_sum <= '0;
          t_idx      <= '0;
        end
        irrb_pkg::ST_RD: begin
          mul_idx <= '0;
        end
        irrb_pkg::ST_ADD: begin
        end
        irrb_pkg::ST_MUL: begin
          mul_idx <= mul_idx + 1'b1;
        end
        irrb_pkg::ST_MACC: begin
        end
        irrb_pkg::ST_RND: begin
          horner_sum <= grow_res;
          t_idx      <= t_idx + 1'b1;
        end
        irrb_pkg::ST_CMP: begin
          if (expanding) begin
            if (keep_expanding) begin
              high_bound <= high_bound <<< 1;
              rate       <= high_bound <<< 1;
            end else begin
              expanding <= 1'b0;
            end
          end else begin
            if (horner_sum > irrb_pkg::SumW'(target)) begin
              high_bound <= rate;
            end else begin
              low_bound <= rate;
            end
            if (step_count != steps_last) begin
              step_count <= step_count + 1'b1;
            end
          end
        end
        irrb_pkg::ST_MID: begin
          rate <= bound_sum[irrb_pkg::RateW:1];
        end
        irrb_pkg::ST_DONE: begin
          if (out_free) begin
            month_count   <= '0;
            overflow_seen <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == irrb_pkg::ST_IDLE && req.valid && req.req_type) begin
      target <= req.money_value;
    end
    if (state == irrb_pkg::ST_ADD) begin
      acc_neg <= add_sat[irrb_pkg::SumW-1];
      acc_mag <= add_sat[irrb_pkg::SumW-1] ? irrb_pkg::MagW'(-add_sat)
                                           : irrb_pkg::MagW'(add_sat);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == irrb_pkg::ST_DONE && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == irrb_pkg::ST_DONE && out_free) begin
      out_rate <= rate;
      out_ovf  <= overflow_seen;
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.monthly_rate   = out_rate;
  assign rsp.store_overflow = out_ovf;

`ifndef ASSERT_OFF
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    month_count <= irrb_pkg::CountW'(irrb_pkg::MaxMonths))
    else $error("month count beyond store depth");

  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == irrb_pkg::ST_DONE && out_free) |=> (month_count == '0 && !overflow_seen))
    else $error("count not cleared after solve");

  a_mid_in_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == irrb_pkg::ST_FV_INIT && !expanding) |->
      (low_bound <= rate && rate <= high_bound))
    else $error("midpoint outside search bounds");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == irrb_pkg::ST_DONE)
    else $error("response raised outside done state");

  a_growth_positive: assert property (@(posedge clk) disable iff (rst)
    (state == irrb_pkg::ST_RND) |-> growth_pos)
    else $error("nonpositive growth during search");
`endif

endmodule

@@ tb/irrb_tb_pkg.sv @@
`timescale 1ns / 1ps
// Request kind codes shared by the solver checker and the stimulus.
package irrb_tb_pkg;

  localparam logic ReqAppend = 1'b0;
  localparam logic ReqSolve  = 1'b1;

endpackage

@@ tb/irrb_checker.sv @@
`timescale 1ns / 1ps
// Checker: tracks the amount store and step setting, predicts each solved rate, checks responses.
module irrb_checker
  import irrb_pkg::*;
  import irrb_tb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  irrb_req_if               req,
  irrb_rsp_if               rsp,
  input  logic              cfg_wr_en,
  input  logic [StepsW-1:0] cfg_wr_data,
  output int                errors,
  output int                pending
);

  typedef struct {
    logic signed [RateW-1:0] rate;
    logic                    ovf;
  } solved_rate_t;

  localparam longint GrowOne   = 64'sd1 <<< RateFracBits;
  localparam longint AccMax    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint RateCeil  = 64'sd1 <<< 39;
  localparam longint RateFloor = -(((64'sd999 <<< RateFracBits) + 500) / 1000);
  localparam longint RateStart = (RateFracBits > 39) ? RateCeil : GrowOne;
  localparam logic [StepsW-1:0] HalvingsAtReset = StepsW'(100);

  logic signed [MoneyW-1:0] amounts [MaxMonths];
  int                       month_cnt;
  logic                     ovf_seen;
  logic [StepsW-1:0]        halvings;
  solved_rate_t             rate_q [$];

  function automatic longint acc_add(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(AccMax)) return AccMax;
    if (s < -65'(AccMax)) return -AccMax;
    return s[63:0];
  endfunction

  function automatic longint acc_grow(longint acc, longint g);
    logic [63:0]  mag;
    logic [127:0] prod;
    if (g <= 0 || acc == 0) return 0;
    mag = (acc < 0) ? -acc : acc;
    prod = {64'd0, mag} * {64'd0, g};
    prod = prod + (128'd1 << (RateFracBits - 1));
    prod = prod >> RateFracBits;
    if (prod > 128'(AccMax)) prod = 128'(AccMax);
    return (acc < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic longint fv_at(longint rate);
    longint acc;
    longint g;
    acc = 0;
    g = GrowOne + rate;
    for (int t = 0; t < month_cnt; t++) acc = acc_grow(acc_add(acc, amounts[t]), g);
    return acc;
  endfunction

  function automatic solved_rate_t solve_rate(longint target);
    longint       lo;
    longint       hi;
    longint       mid;
    int           n;
    solved_rate_t r;
    lo = RateFloor;
    hi = RateStart;
    mid = 0;
    while (fv_at(hi) < target && hi < RateCeil) hi = hi * 2;
    n = (halvings == 0) ? 1 : int'(halvings);
    for (int i = 0; i < n; i++) begin
      mid = (lo + hi) >>> 1;
      if (fv_at(mid) > target) hi = mid;
      else lo = mid;
    end
    r.rate = mid[RateW-1:0];
    r.ovf = ovf_seen;
    return r;
  endfunction

  always @(posedge clk) begin
    solved_rate_t want;
    if (rst) begin
      month_cnt = 0;
      ovf_seen = 1'b0;
      halvings = HalvingsAtReset;
      rate_q.delete();
    end else begin
      if (cfg_wr_en) halvings = cfg_wr_data;
      if (rsp.valid && rsp.ready) begin
        if (rate_q.size() == 0) begin
          $error("unexpected item: monthly_rate %0d store_overflow %0b",
                 rsp.monthly_rate, rsp.store_overflow);
          errors++;
        end else begin
          want = rate_q.pop_front();
          if (rsp.monthly_rate !== want.rate) begin
            $error("monthly_rate: expected %0d, actual %0d", want.rate, rsp.monthly_rate);
            errors++;
          end
          if (rsp.store_overflow !== want.ovf) begin
            $error("store_overflow: expected %0b, actual %0b", want.ovf, rsp.store_overflow);
            errors++;
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.req_type == ReqSolve) begin
          rate_q.push_back(solve_rate(req.money_value));
          month_cnt = 0;
          ovf_seen = 1'b0;
        end else if (month_cnt < MaxMonths) begin
          amounts[month_cnt] = req.money_value;
          month_cnt++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
    end
    pending = rate_q.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the IRR bisection solver testbench: clock, reset, stimulus, handshake idling, verdict.
module tb_top;
  import irrb_pkg::*;
  import irrb_tb_pkg::*;

  localparam longint MoneyMax = (64'sd1 <<< (MoneyW - 1)) - 1;
  localparam longint MoneyMin = -(64'sd1 <<< (MoneyW - 1));

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_wr_en;
  logic [StepsW-1:0] cfg_wr_data;
  int                errors;
  int                pending;
  bit                no_idle;
  longint            month_sum;
  int                items_sent;

  irrb_req_if req ();
  irrb_rsp_if rsp ();

  irr_bisection_solver dut (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  irrb_checker chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .errors      (errors),
    .pending     (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int idle_draw();
    return no_idle ? 0 : int'($urandom_range(0, 15));
  endfunction

  function automatic logic signed [MoneyW-1:0] pick_amount();
    case ($urandom_range(0, 7))
      0:       return MoneyW'({$urandom, $urandom});
      1:       return $urandom_range(0, 1) ? MoneyW'(MoneyMax) : MoneyW'(MoneyMin);
      2, 3:    return MoneyW'(longint'($urandom_range(0, 2097152)) - 1048576);
      default: return MoneyW'(longint'($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic logic signed [MoneyW-1:0] pick_target(longint sum);
    longint t;
    longint spread;
    spread = ((sum < 0) ? -sum : sum) / 4 + 16;
    case ($urandom_range(0, 5))
      0: return MoneyW'({$urandom, $urandom});
      1: return '0;
      default: begin
        t = sum + longint'($urandom) % (2 * spread + 1) - spread;
        if (t > MoneyMax) t = MoneyMax;
        if (t < MoneyMin) t = MoneyMin;
        return MoneyW'(t);
      end
    endcase
  endfunction

  task automatic send(logic kind, logic signed [MoneyW-1:0] value);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.req_type <= kind;
    req.money_value <= value;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic append(logic signed [MoneyW-1:0] value);
    send(ReqAppend, value);
    month_sum += value;
  endtask

  task automatic solve_for(logic signed [MoneyW-1:0] target);
    send(ReqSolve, target);
    month_sum = 0;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_halvings(int v);
    drain();
    cfg_wr_data <= StepsW'(v);
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int stall;
    rsp.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = idle_draw();
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      @(negedge clk);
    end
  end

  initial begin
    int n;
    int v;
    int max_n;
    req.valid = 1'b0;
    req.req_type = ReqAppend;
    req.money_value = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    rst = 1'b1;
    no_idle = 1'b0;
    month_sum = 0;
    items_sent = 0;
    max_n = 5;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // empty store, then bounds pushed to the cap
    solve_for('0);
    solve_for(MoneyW'(MoneyMax));
    append(1000);
    append(1000);
    append(1000);
    solve_for(3100);
    append(MoneyW'(MoneyMax));
    append(MoneyW'(MoneyMin));
    solve_for(MoneyW'(MoneyMin));
    append(-500);
    append(-500);
    solve_for(-2000);
    // zero steps acts as one
    set_halvings(0);
    append(7);
    solve_for(7);
    set_halvings(127);
    append(MoneyW'(MoneyMax));
    solve_for(MoneyW'(MoneyMax));
    set_halvings(1);
    append(1);
    solve_for(MoneyW'(MoneyMin));

    // overfill the store by one
    no_idle = 1'b1;
    repeat (MaxMonths + 1) append(MoneyW'($urandom_range(1, 1000)));
    no_idle = 1'b0;
    solve_for(MoneyW'({$urandom, $urandom}));

    while (items_sent < 2000) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 5))
          0:       v = 127;
          1:       v = 100;
          default: v = $urandom_range(0, 6);
        endcase
        set_halvings(v);
        max_n = (v > 8) ? 1 : 5;
      end
      no_idle = ($urandom_range(0, 4) == 0);
      n = $urandom_range(0, max_n);
      repeat (n) append(pick_amount());
      solve_for(pick_target(month_sum));
      if ($urandom_range(0, 30) == 0) drain();
    end

    drain();
    repeat (32) @(negedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ irr_bisection_solver.f @@
rtl/irrb_pkg.sv
rtl/irrb_req_if.sv
rtl/irrb_rsp_if.sv
rtl/irrb_store.sv
rtl/irrb_mac.sv
rtl/irr_bisection_solver.sv
tb/irrb_tb_pkg.sv
tb/irrb_checker.sv
tb/tb_top.sv
